>>> src/ledenc_pkg.sv
package ledenc_pkg;

  localparam int unsigned BITS_PER_PIXEL_DEF = 24;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned SHORT_TICKS_W = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SHORT_TICKS_W-1:0] ZERO_HIGH_RST = 16'd22;
  localparam logic [SHORT_TICKS_W-1:0] ZERO_LOW_RST = 16'd51;
  localparam logic [SHORT_TICKS_W-1:0] ONE_HIGH_RST = 16'd45;
  localparam logic [SHORT_TICKS_W-1:0] ONE_LOW_RST = 16'd38;
  localparam logic [TICKS_W-1:0] RESET_HIGH_RST = 24'd192000;
  localparam logic [TICKS_W-1:0] RESET_LOW_RST = 24'd12800;
  localparam logic SWAP_RST = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ZERO_HIGH  = 3'd0,
    REG_ZERO_LOW   = 3'd1,
    REG_ONE_HIGH   = 3'd2,
    REG_ONE_LOW    = 3'd3,
    REG_RESET_HIGH = 3'd4,
    REG_RESET_LOW  = 3'd5,
    REG_SWAP       = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_HIGH,
    PH_RST_LOW,
    PH_BIT_HIGH,
    PH_BIT_LOW
  } phase_t;

  typedef struct packed {
    logic [SHORT_TICKS_W-1:0] zero_high;
    logic [SHORT_TICKS_W-1:0] zero_low;
    logic [SHORT_TICKS_W-1:0] one_high;
    logic [SHORT_TICKS_W-1:0] one_low;
    logic [TICKS_W-1:0]       reset_high;
    logic [TICKS_W-1:0]       reset_low;
  } ledenc_cfg_t;

  typedef struct packed {
    logic busy;
    logic fetch;
  } ledenc_status_t;

  function automatic logic [COLOR_W-1:0] swap_rg(input logic [COLOR_W-1:0] rgb);
    swap_rg = {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

>>> src/ledenc_fifo.sv
module ledenc_fifo #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/ledenc_front.sv
module ledenc_front #(
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  logic [ledenc_pkg::COLOR_W-1:0] pixel_color,
  input  logic                           frame_start,
  input  logic                           push,
  input  logic                           full,
  input  logic                           swap_red_green,
  output logic                           wr_en,
  output logic [BITS_PER_PIXEL:0]        wr_data
);
  import ledenc_pkg::*;

  logic [COLOR_W-1:0] color;

  // Reorder to wire order, then widen so extra top bits go out as zero codes.
  assign color   = swap_red_green ? swap_rg(pixel_color) : pixel_color;
  assign wr_en   = push && !full;
  assign wr_data = {frame_start, BITS_PER_PIXEL'(color)};

endmodule

>>> src/ledenc_back.sv
module ledenc_back #(
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ledenc_pkg::ledenc_cfg_t        cfg,
  input  logic                           q_empty,
  input  logic [BITS_PER_PIXEL:0]        q_data,
  output logic                           q_pop,
  output ledenc_pkg::ledenc_status_t     status,
  output logic                           line_level,
  output logic [ledenc_pkg::TICKS_W-1:0] segment_ticks,
  output logic                           last_segment,
  output logic                           empty,
  input  logic                           pop
);
  import ledenc_pkg::*;

  localparam int unsigned CNT_W = $clog2(BITS_PER_PIXEL);

  phase_t                    phase;
  phase_t                    phase_next;
  logic [BITS_PER_PIXEL-1:0] word;
  logic [BITS_PER_PIXEL-1:0] word_next;
  logic [CNT_W-1:0]          bit_cnt;
  logic [CNT_W-1:0]          bit_cnt_next;
  logic                      out_valid;
  logic                      out_valid_next;
  logic                      slot_free;
  logic                      emit;
  logic                      finish;
  logic                      fetch;
  logic                      seg_level;
  logic [TICKS_W-1:0]        seg_ticks;
  logic                      seg_last;

  assign slot_free = !out_valid || pop;
  assign emit      = (phase != PH_IDLE) && slot_free;
  assign finish    = emit && (phase == PH_BIT_LOW) && (bit_cnt == '0);
  assign fetch     = ((phase == PH_IDLE) || finish) && !q_empty;
  assign q_pop     = fetch;
  assign status    = '{busy: (phase != PH_IDLE), fetch: fetch};
  assign empty     = !out_valid;

  always_comb begin
    phase_next   = phase;
    word_next    = word;
    bit_cnt_next = bit_cnt;
    seg_level    = 1'b0;
    seg_ticks    = '0;
    seg_last     = 1'b0;
    unique case (phase)
      PH_IDLE: begin
      end
      PH_RST_HIGH: begin
        seg_level = 1'b1;
        seg_ticks = cfg.reset_high;
        if (slot_free) begin
          phase_next = PH_RST_LOW;
        end
      end
      PH_RST_LOW: begin
        seg_ticks = cfg.reset_low;
        if (slot_free) begin
          phase_next = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        seg_level = 1'b1;
        seg_ticks = word[BITS_PER_PIXEL-1] ? TICKS_W'(cfg.one_high) : TICKS_W'(cfg.zero_high);
        if (slot_free) begin
          phase_next = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        seg_ticks = word[BITS_PER_PIXEL-1] ? TICKS_W'(cfg.one_low) : TICKS_W'(cfg.zero_low);
        seg_last  = (bit_cnt == '0);
        if (slot_free) begin
          // Advance to the next bit, or drop back to idle after the last one.
          if (bit_cnt == '0) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next   = PH_BIT_HIGH;
            word_next    = {word[BITS_PER_PIXEL-2:0], 1'b0};
            bit_cnt_next = bit_cnt - 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    // Pull the next pixel in the same cycle the previous one ends.
    if (fetch) begin
      phase_next   = q_data[BITS_PER_PIXEL] ? PH_RST_HIGH : PH_BIT_HIGH;
      word_next    = q_data[BITS_PER_PIXEL-1:0];
      bit_cnt_next = CNT_W'(BITS_PER_PIXEL - 1);
    end
    out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word    <= word_next;
    bit_cnt <= bit_cnt_next;
    if (emit) begin
      line_level    <= seg_level;
      segment_ticks <= seg_ticks;
      last_segment  <= seg_last;
    end
  end

endmodule

>>> src/addressable_led_bit_encoder.sv
// Addressable LED bit encoder. Push one pixel per beat (24-bit RGB, red in
// 23:16, plus a frame_start flag); pop the line waveform as timed segments,
// each a level and a duration in clock ticks. A pixel with frame_start set is
// preceded by the reset pair (high for reset_high_ticks, then low for
// reset_low_ticks). Each of the BITS_PER_PIXEL data bits, MSB first, gives a
// high segment and a low segment from the zero-code or one-code timings; the
// final low segment of a pixel carries last_segment. With swap_red_green set
// the red and green bytes go out exchanged (GRB wire order). The segment
// generator emits one segment per clock while the output is not stalled by
// pop; the next queued pixel is fetched in the same cycle as the last segment
// of the current one is emitted. A two-entry pixel queue sits in front of the
// generator, so push keeps being taken while segments drain. Configuration is
// written through cfg_valid / cfg_ready (always ready), cfg_index selects the
// register in the order zero high, zero low, one high, one low, reset high,
// reset low, swap; other indexes are ignored. Write configuration only while
// the block is idle.
module addressable_led_bit_encoder #(
  parameter int unsigned BITS_PER_PIXEL = ledenc_pkg::BITS_PER_PIXEL_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // pixel input beat
  input  logic                               push,
  output logic                               full,
  input  logic [ledenc_pkg::COLOR_W-1:0]     pixel_color,
  input  logic                               frame_start,
  // segment output beat
  output logic                               empty,
  input  logic                               pop,
  output logic                               line_level,
  output logic [ledenc_pkg::TICKS_W-1:0]     segment_ticks,
  output logic                               last_segment,
  // configuration write beat
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ledenc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ledenc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ledenc_pkg::*;

  ledenc_cfg_t           cfg;
  logic                  swap_red_green;
  logic                  q_wr_en;
  logic [BITS_PER_PIXEL:0] q_wr_data;
  logic [BITS_PER_PIXEL:0] q_rd_data;
  logic                  q_pop;
  logic                  q_empty;
  ledenc_status_t        status;

  // Configuration registers: always accept, mask to register width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high  <= ZERO_HIGH_RST;
      cfg.zero_low   <= ZERO_LOW_RST;
      cfg.one_high   <= ONE_HIGH_RST;
      cfg.one_low    <= ONE_LOW_RST;
      cfg.reset_high <= RESET_HIGH_RST;
      cfg.reset_low  <= RESET_LOW_RST;
      swap_red_green <= SWAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZERO_HIGH:  cfg.zero_high  <= cfg_data[SHORT_TICKS_W-1:0];
        REG_ZERO_LOW:   cfg.zero_low   <= cfg_data[SHORT_TICKS_W-1:0];
        REG_ONE_HIGH:   cfg.one_high   <= cfg_data[SHORT_TICKS_W-1:0];
        REG_ONE_LOW:    cfg.one_low    <= cfg_data[SHORT_TICKS_W-1:0];
        REG_RESET_HIGH: cfg.reset_high <= cfg_data[TICKS_W-1:0];
        REG_RESET_LOW:  cfg.reset_low  <= cfg_data[TICKS_W-1:0];
        REG_SWAP:       swap_red_green <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: reorder and widen the pixel, tag it with the frame flag.
  ledenc_front #(
    .BITS_PER_PIXEL(BITS_PER_PIXEL)
  ) u_front (
    .pixel_color   (pixel_color),
    .frame_start   (frame_start),
    .push          (push),
    .full          (full),
    .swap_red_green(swap_red_green),
    .wr_en         (q_wr_en),
    .wr_data       (q_wr_data)
  );

  // Pixel queue between front and segment generator.
  ledenc_fifo #(
    .WIDTH(BITS_PER_PIXEL + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr_en),
    .wr_data(q_wr_data),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .full   (full),
    .empty  (q_empty)
  );

  // Back: walk the reset pair and the data bits, one segment per beat.
  ledenc_back #(
    .BITS_PER_PIXEL(BITS_PER_PIXEL)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .status       (status),
    .line_level   (line_level),
    .segment_ticks(segment_ticks),
    .last_segment (last_segment),
    .empty        (empty),
    .pop          (pop)
  );

`ifndef SYNTHESIS
  // The pixel-closing segment is always a low one.
  a_last_is_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_segment) |-> !line_level)
    else $error("last segment with line high");

  // An accepted pixel is held in the queue or already in the generator.
  a_pixel_kept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> (!q_empty || status.busy))
    else $error("accepted pixel lost");

  // The generator only fetches when idle or on its final low segment.
  a_fetch_point: assert property (@(posedge clk) disable iff (rst)
    status.fetch |-> (!status.busy || (!(!empty && !pop) && !q_empty)))
    else $error("pixel fetched mid-stream");
`endif

endmodule

>>> tb/sv/addressable_led_bit_encoder_tb.sv
module addressable_led_bit_encoder_tb;
  import ledenc_pkg::*;

  localparam int unsigned PIXEL_BITS = BITS_PER_PIXEL_DEF;
  // The index field has one code beyond the register list; the block ignores it.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_PIXELS_PER_PHASE = 95;
  localparam int unsigned STALL_PIXELS = 20;

  typedef struct packed {
    logic               level;
    logic [TICKS_W-1:0] ticks;
    logic               last;
  } segment_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [COLOR_W-1:0]     pixel_color;
  logic                   frame_start;
  logic                   empty;
  logic                   pop;
  logic                   line_level;
  logic [TICKS_W-1:0]     segment_ticks;
  logic                   last_segment;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow copy of the timing registers and the byte-order switch.
  ledenc_cfg_t timing;
  logic        swap_on;

  // Segments still owed by the block, oldest first.
  segment_t    segment_q[$];

  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned segments_seen;
  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned cfg_beats;
  bit          saw_full;

  addressable_led_bit_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .pixel_color   (pixel_color),
    .frame_start   (frame_start),
    .empty         (empty),
    .pop           (pop),
    .line_level    (line_level),
    .segment_ticks (segment_ticks),
    .last_segment  (last_segment),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run needs well under a tenth of this.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void load_reset_timing();
    timing.zero_high  = ZERO_HIGH_RST;
    timing.zero_low   = ZERO_LOW_RST;
    timing.one_high   = ONE_HIGH_RST;
    timing.one_low    = ONE_LOW_RST;
    timing.reset_high = RESET_HIGH_RST;
    timing.reset_low  = RESET_LOW_RST;
    swap_on           = SWAP_RST;
  endfunction

  // Turn one accepted pixel into the segments it must produce: the optional
  // reset pair, then a high and a low segment per bit, MSB first.
  function automatic void encode_pixel(logic [COLOR_W-1:0] color, logic start);
    logic [COLOR_W-1:0]    ordered;
    logic [PIXEL_BITS-1:0] word;
    segment_t              seg;
    ordered = swap_on ? {color[15:8], color[23:16], color[7:0]} : color;
    word = PIXEL_BITS'(ordered);  // zero-extend when the pixel is wider than the color
    if (start) begin
      seg = '{level: 1'b1, ticks: timing.reset_high, last: 1'b0};
      segment_q.push_back(seg);
      seg = '{level: 1'b0, ticks: timing.reset_low, last: 1'b0};
      segment_q.push_back(seg);
    end
    for (int b = PIXEL_BITS - 1; b >= 0; b--) begin
      seg.level = 1'b1;
      seg.ticks = word[b] ? TICKS_W'(timing.one_high) : TICKS_W'(timing.zero_high);
      seg.last  = 1'b0;
      segment_q.push_back(seg);
      seg.level = 1'b0;
      seg.ticks = word[b] ? TICKS_W'(timing.one_low) : TICKS_W'(timing.zero_low);
      seg.last  = (b == 0);
      segment_q.push_back(seg);
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Compare one popped beat against the oldest owed segment.
  function automatic void check_segment();
    segment_t want;
    segments_seen++;
    if (segment_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected segment level=%0b ticks=%0d last=%0b",
                              line_level, segment_ticks, last_segment));
      return;
    end
    want = segment_q.pop_front();
    if (line_level !== want.level)
      flag_mismatch($sformatf("line_level: expected %0b, got %0b", want.level, line_level));
    if (segment_ticks !== want.ticks)
      flag_mismatch($sformatf("segment_ticks: expected %0d, got %0d",
                              want.ticks, segment_ticks));
    if (last_segment !== want.last)
      flag_mismatch($sformatf("last_segment: expected %0b, got %0b",
                              want.last, last_segment));
  endfunction

  // Output side: check each accepted beat, then pick pop for the next edge.
  // A pending hold-off keeps pop low and is counted down here, one per cycle.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_segment();
      if (hold_left != 0) hold_left--;
      pop <= !rst && (hold_left == 0) && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offer one pixel, idling first at the current rate, and hold it until
  // the block takes the beat. Push stays high on return; the next caller
  // either offers another pixel or drops it.
  task automatic send_pixel(logic [COLOR_W-1:0] color, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    pixel_color <= color;
    frame_start <= start;
    do begin
      @(posedge clk);
      if (full) saw_full = 1'b1;
    end while (full);
    encode_pixel(color, start);
    pixels_sent++;
    if (start) frames_sent++;
  endtask

  // Drop push and wait until every owed segment has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (segment_q.size() != 0) @(posedge clk);
  endtask

  // One register beat; cfg_valid stays high for a following beat.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ZERO_HIGH:  timing.zero_high  = data[SHORT_TICKS_W-1:0];
      REG_ZERO_LOW:   timing.zero_low   = data[SHORT_TICKS_W-1:0];
      REG_ONE_HIGH:   timing.one_high   = data[SHORT_TICKS_W-1:0];
      REG_ONE_LOW:    timing.one_low    = data[SHORT_TICKS_W-1:0];
      REG_RESET_HIGH: timing.reset_high = data;
      REG_RESET_LOW:  timing.reset_low  = data;
      REG_SWAP:       swap_on           = data[0];
      default: ;
    endcase
    cfg_beats++;
  endtask

  // Write all seven registers back to back, then drop cfg_valid.
  task automatic program_timing(logic [CFG_DATA_W-1:0] zero_high, zero_low,
                                one_high, one_low, reset_high, reset_low, swap);
    write_reg(REG_ZERO_HIGH, zero_high);
    write_reg(REG_ZERO_LOW, zero_low);
    write_reg(REG_ONE_HIGH, one_high);
    write_reg(REG_ONE_LOW, one_low);
    write_reg(REG_RESET_HIGH, reset_high);
    write_reg(REG_RESET_LOW, reset_low);
    write_reg(REG_SWAP, swap);
    cfg_valid <= 1'b0;
  endtask

  // Mostly ordinary tick counts, now and then zero or all ones. Upper bits
  // beyond a 16-bit register stay random so the width masking is exercised.
  function automatic logic [CFG_DATA_W-1:0] pick_ticks();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Registers at their reset values: blank, white, pure primaries, a mix.
  task automatic test_default_timing();
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h0000FF, 1'b1);
    send_pixel(24'h5AC33C, 1'b0);
  endtask

  // Largest, zero and smallest timings, both byte orders, and an index past
  // the register list that must change nothing.
  task automatic test_timing_extremes();
    wait_drained();
    write_reg(REG_NONE, 24'h5A5A5A);
    program_timing('1, '1, '1, '1, '1, '1, 24'hFFFFFE);
    send_pixel(24'h800001, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);

    wait_drained();
    program_timing('0, '0, '0, '0, '0, '0, 24'h000001);
    send_pixel(24'hA5A5A5, 1'b1);
    send_pixel(24'h0F0F0F, 1'b0);
    send_pixel(24'hF0F0F0, 1'b0);

    wait_drained();
    write_reg(REG_NONE, 24'hA5A5A5);
    program_timing(24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'hFFFFFF);
    send_pixel(24'h123456, 1'b1);
    send_pixel(24'hEDCBA9, 1'b0);
    send_pixel(24'hFF00FF, 1'b1);
  endtask

  // Frames of random pixels under fresh random timings, one idling pattern
  // per phase. Most frames open with frame_start; a few flags land at random.
  task automatic test_random_frames();
    int unsigned        pixels_left;
    int unsigned        frame_len;
    logic               start;
    logic [COLOR_W-1:0] color;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 57; end
        default: begin send_idle_pct = 6;  pop_stall_pct = 6;  end
      endcase
      program_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                     pick_ticks(), pick_ticks(), CFG_DATA_W'($urandom));
      pixels_left = RANDOM_PIXELS_PER_PHASE;
      while (pixels_left != 0) begin
        frame_len = $urandom_range(12, 1);
        for (int i = 0; i < frame_len && pixels_left != 0; i++) begin
          start = (i == 0);
          if ($urandom_range(9) == 0) start = 1'($urandom_range(1));
          color = COLOR_W'($urandom);
          send_pixel(color, start);
          pixels_left--;
        end
      end
    end
  endtask

  // Hold pop low for a long stretch while pixels keep coming, so the pixel
  // queue fills and full pushes back on the input.
  task automatic test_output_stall();
    wait_drained();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < STALL_PIXELS; i++) send_pixel(COLOR_W'($urandom), i == 0);
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    pixel_color   = '0;
    frame_start   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_left     = 0;
    mismatches    = 0;
    segments_seen = 0;
    pixels_sent   = 0;
    frames_sent   = 0;
    cfg_beats     = 0;
    saw_full      = 1'b0;
    load_reset_timing();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_default_timing();
    test_timing_extremes();
    test_random_frames();
    test_output_stall();

    // Let any stray beats show up before judging.
    wait_drained();
    repeat (4 * PIXEL_BITS) @(posedge clk);

    $display("Encoded %0d pixels (%0d with frame start), %0d segments checked, %0d register beats",
             pixels_sent, frames_sent, segments_seen, cfg_beats);
    $display("Timings at reset, zero, one and full scale; both byte orders; input backpressure %s",
             saw_full ? "seen" : "not seen");
    if (mismatches == 0 && segment_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
